// ===== hdl/ctok_pkg.sv =====
// Shared types, character codes and keyword tables for the C-minus tokenizer.
// Depends on nothing; imported by c_minus_tokenizer.
package ctok_pkg;

	localparam int MAX_LEXEME_DEF = 32;
	localparam int LINE_BITS_DEF  = 16;
	localparam int NUM_KW         = 6;
	localparam int KW_MAX_LEN     = 6;

	typedef logic [2:0] kind_t;

	localparam kind_t KIND_ID  = 3'd0;
	localparam kind_t KIND_KEY = 3'd1;
	localparam kind_t KIND_NUM = 3'd2;
	localparam kind_t KIND_SYM = 3'd3;
	localparam kind_t KIND_ERR = 3'd4;

	localparam logic OP_BYTE  = 1'b0;
	localparam logic OP_FLUSH = 1'b1;

	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_BANG  = 8'h21;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_GT    = 8'h3E;

	// if, int, void, else, while, return (zero padded)
	localparam logic [7:0] KW_TEXT [NUM_KW][KW_MAX_LEN] = '{
		'{8'h69, 8'h66, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h69, 8'h6E, 8'h74, 8'h00, 8'h00, 8'h00},
		'{8'h76, 8'h6F, 8'h69, 8'h64, 8'h00, 8'h00},
		'{8'h65, 8'h6C, 8'h73, 8'h65, 8'h00, 8'h00},
		'{8'h77, 8'h68, 8'h69, 8'h6C, 8'h65, 8'h00},
		'{8'h72, 8'h65, 8'h74, 8'h75, 8'h72, 8'h6E}
	};
	localparam logic [2:0] KW_LEN [NUM_KW] = '{3'd2, 3'd3, 3'd4, 3'd4, 3'd5, 3'd6};

	// Keyword character at a position; zero beyond the table
	function automatic logic [7:0] kw_char(input logic [2:0] kw, input logic [2:0] pos);
		logic [7:0] c;
		c = '0;
		if (kw < 3'(NUM_KW) && pos < 3'(KW_MAX_LEN)) begin
			c = KW_TEXT[kw][pos];
		end
		return c;
	endfunction

	function automatic logic alpha_char(input logic [7:0] c);
		return c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
	endfunction

	function automatic logic numeral_char(input logic [7:0] c);
		return c inside {[8'h30:8'h39]};
	endfunction

	// + - * ; , ( ) [ ] { }
	function automatic logic is_single_sym(input logic [7:0] c);
		return c inside {8'h2B, 8'h2D, 8'h2A, 8'h3B, 8'h2C, 8'h28, 8'h29,
			8'h5B, 8'h5D, 8'h7B, 8'h7D};
	endfunction

endpackage

// ===== hdl/c_minus_tokenizer.sv =====
// C-minus tokenizer: each byte beat is held in a register and scanned from there; results leave
// through the output register. Bytes that only update state stream at one per cycle. A token
// leaves one character per cycle while out_stall is low; a byte that ends a word first opens
// the drain, then each stored character is sent, and then the byte is rescanned.
// Reset clears scan mode, lengths, flags and the output valid; lines restart at one. The lexeme
// store is not cleared, as only written entries are read.
// Depends on ctok_pkg.
module c_minus_tokenizer import ctok_pkg::*; #(
	parameter int MAX_LEXEME = MAX_LEXEME_DEF,
	parameter int LINE_BITS  = LINE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        op,
	input  logic [7:0]  glyph_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output kind_t       token_kind,
	output logic [15:0] line_number,
	output logic [7:0]  lexeme_byte,
	output logic        last_of_token,
	output logic        truncated
);

	localparam int ADDR_W = $clog2(MAX_LEXEME);
	localparam int LEN_W  = $clog2(MAX_LEXEME + 1);
	localparam logic [LEN_W-1:0]     LEN_FULL = LEN_W'(MAX_LEXEME);
	localparam logic [LEN_W-1:0]     LEN_ONE  = LEN_W'(1);
	localparam logic [LINE_BITS-1:0] LINE_TOP = '1;
	localparam logic [LINE_BITS-1:0] LINE_ONE = LINE_BITS'(1);

	// scan modes, then drain modes that emit stored or fixed characters
	localparam logic [3:0] M_IDLE    = 4'd0;
	localparam logic [3:0] M_IDENT   = 4'd1;
	localparam logic [3:0] M_NUMBER  = 4'd2;
	localparam logic [3:0] M_SLASH   = 4'd3;
	localparam logic [3:0] M_LT      = 4'd4;
	localparam logic [3:0] M_GT      = 4'd5;
	localparam logic [3:0] M_EQ      = 4'd6;
	localparam logic [3:0] M_BANG    = 4'd7;
	localparam logic [3:0] M_COMMENT = 4'd8;
	localparam logic [3:0] M_CSTAR   = 4'd9;
	localparam logic [3:0] M_WORD    = 4'd10;
	localparam logic [3:0] M_SYM2    = 4'd11;
	localparam logic [3:0] M_CERR2   = 4'd12;

	logic [3:0]           mode_q, mode_d;
	logic                 have_q;
	logic                 op_q;
	logic [7:0]           byte_q;
	logic [7:0]           lexmem [MAX_LEXEME];
	logic [7:0]           rd_data_q;
	logic [ADDR_W-1:0]    rd_addr, wr_addr, idx_q;
	logic [LEN_W-1:0]     len_q;
	logic                 ovf_q;
	logic                 word_num_q;
	logic [NUM_KW-1:0]    kw_q, kw_start, kw_next, len_hit;
	logic [LINE_BITS-1:0] cur_line_q, cmt_line_q, line_sel;
	logic [LINE_BITS+15:0] line_ext;

	logic                 ov_q, last_q, trunc_q;
	kind_t                kind_q;
	logic [15:0]          line_q;
	logic [7:0]           char_q;

	logic       is_flush, can_emit, go, idx_last, is_kw;
	logic       emit_req, e_last, e_trunc, e_cline;
	kind_t      e_kind, word_kind;
	logic [7:0] e_char, pair_char;
	logic       consume, start_word, append, enter_word, drain_adv, bump, set_cline;

	assign is_flush = (op_q == OP_FLUSH);
	assign can_emit = !ov_q || !out_stall;
	assign idx_last = (LEN_W'(LEN_W'(idx_q) + LEN_ONE) == len_q);
	assign pair_char = (mode_q == M_LT) ? CH_LT : ((mode_q == M_GT) ? CH_GT : CH_EQ);

	// keyword tracking: one flag per keyword, narrowed on each append that is stored
	always_comb begin
		for (int i = 0; i < NUM_KW; i++) begin
			kw_start[i] = (byte_q == kw_char(3'(i), 3'd0));
			kw_next[i]  = kw_q[i] && (len_q < LEN_W'(KW_LEN[i]))
				&& (byte_q == kw_char(3'(i), len_q[2:0]));
			len_hit[i]  = (len_q == LEN_W'(KW_LEN[i]));
		end
	end

	assign is_kw = !ovf_q && |(kw_q & len_hit);
	assign word_kind = word_num_q ? KIND_NUM : (is_kw ? KIND_KEY : KIND_ID);

	// one step of the scanner on the held beat
	always_comb begin
		mode_d     = mode_q;
		emit_req   = 1'b0;
		e_kind     = KIND_SYM;
		e_char     = byte_q;
		e_last     = 1'b1;
		e_trunc    = 1'b0;
		e_cline    = 1'b0;
		consume    = 1'b0;
		start_word = 1'b0;
		append     = 1'b0;
		enter_word = 1'b0;
		drain_adv  = 1'b0;
		bump       = 1'b0;
		set_cline  = 1'b0;
		case (mode_q)
			M_IDLE: begin
				consume = 1'b1;
				if (!is_flush) begin
					if (alpha_char(byte_q)) begin
						start_word = 1'b1;
						mode_d     = M_IDENT;
					end else if (numeral_char(byte_q)) begin
						start_word = 1'b1;
						mode_d     = M_NUMBER;
					end else if (is_single_sym(byte_q)) begin
						emit_req = 1'b1;
					end else begin
						case (byte_q)
							CH_SLASH: mode_d = M_SLASH;
							CH_LT:    mode_d = M_LT;
							CH_GT:    mode_d = M_GT;
							CH_EQ:    mode_d = M_EQ;
							CH_BANG:  mode_d = M_BANG;
							CH_NL:    bump   = 1'b1;
							CH_SP, CH_TAB: ;
							default: begin
								emit_req = 1'b1;
								e_kind   = KIND_ERR;
							end
						endcase
					end
				end
			end
			M_IDENT, M_NUMBER: begin
				if (!is_flush && (numeral_char(byte_q)
						|| (mode_q == M_IDENT && alpha_char(byte_q)))) begin
					append  = 1'b1;
					consume = 1'b1;
				end else begin
					// drain the word, then rescan this beat
					enter_word = 1'b1;
					mode_d     = M_WORD;
				end
			end
			M_WORD: begin
				emit_req = 1'b1;
				e_kind   = word_kind;
				e_char   = rd_data_q;
				e_last   = idx_last;
				e_trunc  = ovf_q;
				if (idx_last) begin
					mode_d = M_IDLE;
				end else begin
					drain_adv = 1'b1;
				end
			end
			M_SLASH: begin
				if (!is_flush && byte_q == CH_STAR) begin
					set_cline = 1'b1;
					consume   = 1'b1;
					mode_d    = M_COMMENT;
				end else begin
					emit_req = 1'b1;
					e_char   = CH_SLASH;
					mode_d   = M_IDLE;
				end
			end
			M_LT, M_GT, M_EQ: begin
				emit_req = 1'b1;
				e_char   = pair_char;
				if (!is_flush && byte_q == CH_EQ) begin
					e_last = 1'b0;
					mode_d = M_SYM2;
				end else begin
					mode_d = M_IDLE;
				end
			end
			M_BANG: begin
				emit_req = 1'b1;
				e_char   = CH_BANG;
				if (!is_flush && byte_q == CH_EQ) begin
					e_last = 1'b0;
					mode_d = M_SYM2;
				end else begin
					// lone bang: error, and the beat is rescanned
					e_kind = KIND_ERR;
					mode_d = M_IDLE;
				end
			end
			M_SYM2: begin
				emit_req = 1'b1;
				e_char   = CH_EQ;
				consume  = 1'b1;
				mode_d   = M_IDLE;
			end
			M_COMMENT, M_CSTAR: begin
				if (is_flush) begin
					// unterminated comment
					emit_req = 1'b1;
					e_kind   = KIND_ERR;
					e_char   = CH_SLASH;
					e_last   = 1'b0;
					e_cline  = 1'b1;
					mode_d   = M_CERR2;
				end else begin
					consume = 1'b1;
					if (byte_q == CH_STAR) begin
						mode_d = M_CSTAR;
					end else if (mode_q == M_CSTAR && byte_q == CH_SLASH) begin
						mode_d = M_IDLE;
					end else begin
						bump   = (byte_q == CH_NL);
						mode_d = M_COMMENT;
					end
				end
			end
			M_CERR2: begin
				emit_req = 1'b1;
				e_kind   = KIND_ERR;
				e_char   = CH_STAR;
				e_cline  = 1'b1;
				mode_d   = M_IDLE;
			end
			default: mode_d = M_IDLE;
		endcase
	end

	assign go       = have_q && (!emit_req || can_emit);
	assign in_stall = have_q && !(go && consume);

	assign wr_addr = start_word ? '0 : len_q[ADDR_W-1:0];
	assign rd_addr = (mode_q == M_WORD) ? ((go && drain_adv) ? ADDR_W'(idx_q + 1'b1) : idx_q)
		: '0;

	// lexeme store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (go && (start_word || (append && len_q != LEN_FULL))) begin
			lexmem[wr_addr] <= byte_q;
		end
		rd_data_q <= lexmem[rd_addr];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= M_IDLE;
			have_q     <= 1'b0;
			len_q      <= '0;
			ovf_q      <= 1'b0;
			cur_line_q <= LINE_ONE;
			cmt_line_q <= LINE_ONE;
			ov_q       <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				have_q <= 1'b1;
			end else if (go && consume) begin
				have_q <= 1'b0;
			end
			if (go) begin
				mode_q <= mode_d;
			end
			if (go && start_word) begin
				len_q <= LEN_ONE;
				ovf_q <= 1'b0;
			end else if (go && append) begin
				if (len_q != LEN_FULL) begin
					len_q <= len_q + LEN_ONE;
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (go && bump && cur_line_q != LINE_TOP) begin
				cur_line_q <= cur_line_q + LINE_ONE;
			end
			if (go && set_cline) begin
				cmt_line_q <= cur_line_q;
			end
			if (go && emit_req) begin
				ov_q <= 1'b1;
			end else if (!out_stall) begin
				ov_q <= 1'b0;
			end
		end
	end

	assign line_sel = e_cline ? cmt_line_q : cur_line_q;
	assign line_ext = {16'b0, line_sel};

	// held beat, word bookkeeping and result register
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_q   <= op;
			byte_q <= glyph_byte;
		end
		if (go && start_word) begin
			kw_q       <= kw_start;
			word_num_q <= numeral_char(byte_q);
		end else if (go && append && len_q != LEN_FULL) begin
			kw_q <= kw_next;
		end
		if (go && enter_word) begin
			idx_q <= '0;
		end else if (go && drain_adv) begin
			idx_q <= ADDR_W'(idx_q + 1'b1);
		end
		if (go && emit_req) begin
			kind_q  <= e_kind;
			line_q  <= line_ext[15:0];
			char_q  <= e_char;
			last_q  <= e_last;
			trunc_q <= e_trunc;
		end
	end

	assign out_valid     = ov_q;
	assign token_kind    = kind_q;
	assign line_number   = line_q;
	assign lexeme_byte   = char_q;
	assign last_of_token = last_q;
	assign truncated     = trunc_q;

	// drain modes always hold the beat that caused them
	a_drain_holds_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == M_WORD || mode_q == M_SYM2 || mode_q == M_CERR2) |-> have_q)
		else $error("drain mode without a held beat");

	a_drain_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == M_WORD) |-> (LEN_W'(idx_q) < len_q))
		else $error("drain index beyond lexeme length");

	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> (len_q == LEN_FULL))
		else $error("overflow flagged with store not full");

	a_word_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == M_IDENT || mode_q == M_NUMBER) |-> (len_q != '0))
		else $error("word mode with empty lexeme");

	a_emit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		(go && emit_req) |=> out_valid)
		else $error("emitted character not presented");

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for c_minus_tokenizer: drives source byte and flush beats,
// predicts every lexeme character in a behavioural model and checks each output beat.
// Depends on ctok_pkg and the c_minus_tokenizer top level.
module tb_top import ctok_pkg::*; ();

	localparam int MAX_LEX = MAX_LEXEME_DEF;
	localparam int unsigned LINE_TOP = (1 << LINE_BITS_DEF) - 1;
	localparam int QUIET_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 60;
	localparam int HOLDOFF_CYCLES = 400;
	localparam int RANDOM_BEATS = 96;

	localparam logic [47:0] RW_IF     = "if";
	localparam logic [47:0] RW_INT    = "int";
	localparam logic [47:0] RW_VOID   = "void";
	localparam logic [47:0] RW_ELSE   = "else";
	localparam logic [47:0] RW_WHILE  = "while";
	localparam logic [47:0] RW_RETURN = "return";

	typedef enum logic [3:0] {
		SCAN_IDLE, SCAN_WORD, SCAN_NUM, SCAN_SLASH, SCAN_LT, SCAN_GT, SCAN_EQ,
		SCAN_BANG, SCAN_COMMENT, SCAN_STAR
	} scan_t;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] line;
		logic [7:0]  ch;
		logic        is_last;
		logic        trunc;
	} lex_char_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        op = OP_BYTE;
	logic [7:0]  glyph_byte = 8'h00;
	logic        out_valid;
	logic        out_stall = 1'b0;
	kind_t       token_kind;
	logic [15:0] line_number;
	logic [7:0]  lexeme_byte;
	logic        last_of_token;
	logic        truncated;

	// tokenizer state as predicted
	scan_t       scan;
	logic [7:0]  lex_buf [MAX_LEX];
	int          lex_len;
	logic        lex_over;
	int unsigned line_now;
	int unsigned line_comment;
	lex_char_t   expected_chars [$];

	int          bad_chars = 0;
	int          beats_sent = 0;
	int          idle_pct = 25;
	int          holdoff_len = 0;
	int          stall_left = 0;
	string       kw_list [6] = '{"if", "int", "void", "else", "while", "return"};
	string       pair_list [9] = '{"<=", ">=", "==", "!=", "<", ">", "=", "!", "/"};
	string       sym_list = "+-*;,()[]{}";

	c_minus_tokenizer u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.op            (op),
		.glyph_byte    (glyph_byte),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.token_kind    (token_kind),
		.line_number   (line_number),
		.lexeme_byte   (lexeme_byte),
		.last_of_token (last_of_token),
		.truncated     (truncated)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// ---------------------------------------------------------------- prediction

	function automatic logic is_alpha_b(logic [7:0] b);
		return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
	endfunction

	function automatic logic is_num_b(logic [7:0] b);
		return b >= "0" && b <= "9";
	endfunction

	function automatic void push_char(kind_t k, int unsigned ln, logic [7:0] c, logic fin,
			logic tr);
		lex_char_t e;
		e.kind = k;
		e.line = ln[15:0];
		e.ch = c;
		e.is_last = fin;
		e.trunc = tr;
		expected_chars.push_back(e);
	endfunction

	function automatic void emit_char(kind_t k, logic [7:0] c);
		push_char(k, line_now, c, 1'b1, 1'b0);
	endfunction

	function automatic void bump_line();
		if (line_now < LINE_TOP) line_now++;
	endfunction

	function automatic void add_char(logic [7:0] b);
		if (lex_len < MAX_LEX) begin
			lex_buf[lex_len] = b;
			lex_len++;
		end else begin
			lex_over = 1'b1;
		end
	endfunction

	function automatic logic [7:0] pair_head();
		case (scan)
			SCAN_LT: return CH_LT;
			SCAN_GT: return CH_GT;
			default: return CH_EQ;
		endcase
	endfunction

	// Emit the pending identifier or number, classed as keyword where it matches
	function automatic void close_word();
		kind_t k;
		logic [47:0] w;
		w = '0;
		k = KIND_ID;
		if (scan == SCAN_NUM) begin
			k = KIND_NUM;
		end else if (!lex_over && lex_len >= 2 && lex_len <= 6) begin
			for (int i = 0; i < lex_len; i++) w = {w[39:0], lex_buf[i]};
			if (w == RW_IF || w == RW_INT || w == RW_VOID || w == RW_ELSE ||
					w == RW_WHILE || w == RW_RETURN) k = KIND_KEY;
		end
		for (int i = 0; i < lex_len; i++)
			push_char(k, line_now, lex_buf[i], i == lex_len - 1, lex_over);
		lex_len = 0;
		lex_over = 1'b0;
		scan = SCAN_IDLE;
	endfunction

	// Scan a byte from the idle state
	function automatic void scan_fresh(logic [7:0] b);
		scan = SCAN_IDLE;
		if (is_alpha_b(b) || is_num_b(b)) begin
			lex_len = 0;
			lex_over = 1'b0;
			add_char(b);
			scan = is_alpha_b(b) ? SCAN_WORD : SCAN_NUM;
		end else begin
			case (b)
				"+", "-", "*", ";", ",", "(", ")", "[", "]", "{", "}": emit_char(KIND_SYM, b);
				CH_SLASH: scan = SCAN_SLASH;
				CH_LT: scan = SCAN_LT;
				CH_GT: scan = SCAN_GT;
				CH_EQ: scan = SCAN_EQ;
				CH_BANG: scan = SCAN_BANG;
				CH_NL: bump_line();
				CH_SP, CH_TAB: ;
				default: emit_char(KIND_ERR, b);
			endcase
		end
	endfunction

	// Advance the predicted state by one accepted beat and queue its characters
	function automatic void tokenize_beat(logic o, logic [7:0] b);
		if (o == OP_FLUSH) begin
			case (scan)
				SCAN_WORD, SCAN_NUM: close_word();
				SCAN_SLASH: emit_char(KIND_SYM, CH_SLASH);
				SCAN_LT, SCAN_GT, SCAN_EQ: emit_char(KIND_SYM, pair_head());
				SCAN_BANG: emit_char(KIND_ERR, CH_BANG);
				SCAN_COMMENT, SCAN_STAR: begin
					push_char(KIND_ERR, line_comment, CH_SLASH, 1'b0, 1'b0);
					push_char(KIND_ERR, line_comment, CH_STAR, 1'b1, 1'b0);
				end
				default: ;
			endcase
			scan = SCAN_IDLE;
		end else begin
			case (scan)
				SCAN_WORD: begin
					if (is_alpha_b(b) || is_num_b(b)) begin
						add_char(b);
					end else begin
						close_word();
						scan_fresh(b);
					end
				end
				SCAN_NUM: begin
					if (is_num_b(b)) begin
						add_char(b);
					end else begin
						close_word();
						scan_fresh(b);
					end
				end
				SCAN_SLASH: begin
					if (b == CH_STAR) begin
						line_comment = line_now;
						scan = SCAN_COMMENT;
					end else begin
						emit_char(KIND_SYM, CH_SLASH);
						scan_fresh(b);
					end
				end
				SCAN_LT, SCAN_GT, SCAN_EQ: begin
					if (b == CH_EQ) begin
						push_char(KIND_SYM, line_now, pair_head(), 1'b0, 1'b0);
						push_char(KIND_SYM, line_now, CH_EQ, 1'b1, 1'b0);
						scan = SCAN_IDLE;
					end else begin
						emit_char(KIND_SYM, pair_head());
						scan_fresh(b);
					end
				end
				SCAN_BANG: begin
					if (b == CH_EQ) begin
						push_char(KIND_SYM, line_now, CH_BANG, 1'b0, 1'b0);
						push_char(KIND_SYM, line_now, CH_EQ, 1'b1, 1'b0);
						scan = SCAN_IDLE;
					end else begin
						// lone bang: report it, then rescan the byte
						emit_char(KIND_ERR, CH_BANG);
						scan_fresh(b);
					end
				end
				SCAN_COMMENT: begin
					if (b == CH_STAR) scan = SCAN_STAR;
					else if (b == CH_NL) bump_line();
				end
				SCAN_STAR: begin
					if (b == CH_SLASH) begin
						scan = SCAN_IDLE;
					end else if (b != CH_STAR) begin
						if (b == CH_NL) bump_line();
						scan = SCAN_COMMENT;
					end
				end
				default: scan_fresh(b);
			endcase
		end
	endfunction

	// ---------------------------------------------------------------- output side

	function automatic void take_result();
		lex_char_t want, got;
		got = {token_kind, line_number, lexeme_byte, last_of_token, truncated};
		if (expected_chars.size() == 0) begin
			if (bad_chars < 10)
				$display("%0t: unexpected beat kind %0d line %0d byte %02h last %b trunc %b",
					$time, got.kind, got.line, got.ch, got.is_last, got.trunc);
			bad_chars++;
		end else begin
			want = expected_chars.pop_front();
			if (got.kind !== want.kind || got.line !== want.line || got.ch !== want.ch ||
					got.is_last !== want.is_last || got.trunc !== want.trunc) begin
				if (bad_chars < 10) begin
					$display("%0t: mismatch exp kind %0d line %0d byte %02h last %b trunc %b",
						$time, want.kind, want.line, want.ch, want.is_last, want.trunc);
					$display("%0t:          got kind %0d line %0d byte %02h last %b trunc %b",
						$time, got.kind, got.line, got.ch, got.is_last, got.trunc);
				end
				bad_chars++;
			end
		end
	endfunction

	// Check accepted beats, then pick the stall for the next cycle
	always @(posedge clk) begin
		if (out_valid && !out_stall) take_result();
		if (holdoff_len > 0) begin
			stall_left = holdoff_len;
			holdoff_len = 0;
		end else if (stall_left == 0 && idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
			stall_left = $urandom_range(1, 9);
		end
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Drop the run if no beat moves on either side for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if (arst_n && !((in_valid && !in_stall) || (out_valid && !out_stall))) quiet++;
			else quiet = 0;
		end
		$display("watchdog: %0d cycles without a beat", QUIET_LIMIT);
		$display("[FAIL] regression broken");
		$finish;
	end

	// ---------------------------------------------------------------- input side

	task automatic rest_input(int n);
		in_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// Offer one beat, hold it until accepted, then predict
	task automatic send_beat(logic o, logic [7:0] b);
		if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) rest_input($urandom_range(1, 9));
		in_valid <= 1'b1;
		op <= o;
		glyph_byte <= b;
		do @(posedge clk); while (!(in_valid && !in_stall));
		tokenize_beat(o, b);
		beats_sent++;
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++) send_beat(OP_BYTE, s[i]);
	endtask

	task automatic send_flush();
		send_beat(OP_FLUSH, 8'($urandom_range(0, 255)));
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_chars.size() != 0) @(posedge clk);
	endtask

	function automatic logic [7:0] rand_letter();
		logic [7:0] c;
		if ($urandom_range(0, 1)) c = 8'($urandom_range(97, 122));
		else c = 8'($urandom_range(65, 90));
		return c;
	endfunction

	task automatic send_word(bit digits_only, int n);
		logic [7:0] c;
		for (int i = 0; i < n; i++) begin
			if (digits_only) c = 8'($urandom_range(48, 57));
			else if (i == 0 || $urandom_range(0, 3) != 0) c = rand_letter();
			else c = 8'($urandom_range(48, 57));
			send_beat(OP_BYTE, c);
		end
	endtask

	function automatic int rand_length();
		if ($urandom_range(0, 11) == 0) return $urandom_range(MAX_LEX - 2, MAX_LEX + 4);
		return $urandom_range(1, 8);
	endfunction

	// Send a comment with random body; some are left open and flushed
	task automatic send_comment();
		logic [7:0] c;
		send_text("/*");
		repeat ($urandom_range(0, 10)) begin
			case ($urandom_range(0, 5))
				0: c = CH_NL;
				1: c = CH_STAR;
				2: c = CH_SP;
				3: c = 8'($urandom_range(0, 255));
				default: c = rand_letter();
			endcase
			send_beat(OP_BYTE, c);
		end
		if ($urandom_range(0, 4) == 0) send_flush();
		else if ($urandom_range(0, 3) == 0) send_text("**/");
		else send_text("*/");
	endtask

	// Send one lexeme or piece of noise, then maybe a separator
	task automatic send_random_lexeme();
		int pick;
		logic [7:0] c;
		pick = $urandom_range(0, 99);
		if (pick < 15) begin
			send_text(kw_list[$urandom_range(0, 5)]);
		end else if (pick < 35) begin
			send_word(1'b0, rand_length());
		end else if (pick < 50) begin
			send_word(1'b1, rand_length());
		end else if (pick < 62) begin
			send_beat(OP_BYTE, sym_list[$urandom_range(0, sym_list.len() - 1)]);
		end else if (pick < 72) begin
			send_text(pair_list[$urandom_range(0, 8)]);
		end else if (pick < 80) begin
			send_comment();
		end else if (pick < 85) begin
			send_beat(OP_BYTE, CH_NL);
		end else if (pick < 91) begin
			case ($urandom_range(0, 2))
				0: c = 8'($urandom_range(128, 255));
				1: c = 8'($urandom_range(0, 8));
				default: c = 8'($urandom_range(11, 31));
			endcase
			send_beat(OP_BYTE, c);
		end else if (pick < 96) begin
			send_beat(OP_BYTE, 8'($urandom_range(0, 255)));
		end else begin
			send_flush();
		end
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: send_beat(OP_BYTE, CH_SP);
			6: send_beat(OP_BYTE, CH_NL);
			7: send_beat(OP_BYTE, CH_TAB);
			default: ;
		endcase
	endtask

	// ---------------------------------------------------------------- tests

	// Invalid bytes at the edges of the byte range, and a flush with nothing pending
	task automatic test_char_extremes();
		send_beat(OP_BYTE, 8'h00);
		send_beat(OP_BYTE, 8'hFF);
		send_beat(OP_BYTE, 8'h80);
		send_beat(OP_BYTE, 8'h0D);
		send_beat(OP_BYTE, 8'h7F);
		send_beat(OP_FLUSH, 8'hFF);
	endtask

	// Keyword ended by a comment, two-character operator, lone bang, pending flushes
	task automatic test_operators_and_comments();
		send_text("if/*\n*/x!=!y");
		send_flush();
		send_text("9<");
		send_flush();
		send_text("\n/*");
		send_flush();
	endtask

	task automatic test_random_source();
		int goal;
		for (int seg = 0; seg < 6; seg++) begin
			idle_pct = (seg % 3 == 0) ? 0 : $urandom_range(10, 60);
			goal = beats_sent + RANDOM_BEATS / 6;
			while (beats_sent < goal) send_random_lexeme();
		end
		send_flush();
	endtask

	// Hold the output off while bytes keep coming so the block backs up
	task automatic test_output_holdoff();
		idle_pct = 0;
		holdoff_len = HOLDOFF_CYCLES;
		repeat (50) begin
			send_beat(OP_BYTE, sym_list[$urandom_range(0, sym_list.len() - 1)]);
			if ($urandom_range(0, 3) == 0) send_word(1'b0, 3);
		end
		send_flush();
		wait_drained();
	endtask

	// Advance the line counter over a run of newlines, then check tokens and an open comment
	task automatic test_line_count();
		idle_pct = 0;
		repeat (8) send_beat(OP_BYTE, CH_NL);
		send_text("while x1 <= 7;\n/*\n");
		send_flush();
		send_text("return 0");
		send_flush();
	endtask

	initial begin
		scan = SCAN_IDLE;
		lex_len = 0;
		lex_over = 1'b0;
		line_now = 1;
		line_comment = 1;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_char_extremes();
		test_operators_and_comments();
		wait_drained();
		test_random_source();
		test_output_holdoff();
		idle_pct = 20;
		test_random_source();
		test_line_count();
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (bad_chars == 0 && expected_chars.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
